[design/mvn_pkg.sv]
// ----------------------------------------------------------------------------
// Mesh vertex normal engine package
// Shared item types, request and status codes, and accumulator limits.
// ----------------------------------------------------------------------------
package mvn_pkg;

  localparam int IDX_W   = 10;
  localparam int FIELD_W = 16;
  localparam int NORM_W  = 16;
  localparam int ACC_W   = 26;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic signed [ACC_W:0] ACC_MAX = 27'sd33554431;
  localparam logic signed [ACC_W:0] ACC_MIN = -27'sd33554432;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         vertex_index;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [IDX_W-1:0]         item_index;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                req;
    logic                      bad;
    logic [IDX_W-1:0]          idx_a;
    logic [IDX_W-1:0]          idx_b;
    logic [IDX_W-1:0]          idx_c;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic                     degen;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } norm_res_t;

endpackage

[design/mvn_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mvn_fifo.sv]
// ----------------------------------------------------------------------------
// Small queue
// Register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mvn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        mem_r[wr_ptr_r] <= wdata;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[design/mvn_norm.sv]
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a signed vector to a Q1.14 unit vector with a bit-serial divider
// and a bit-serial square root, one component after the other.
// ----------------------------------------------------------------------------
module mvn_norm #(
  parameter int IN_W = 35
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [IN_W-1:0] vec_x,
  input  logic signed [IN_W-1:0] vec_y,
  input  logic signed [IN_W-1:0] vec_z,
  output logic                   done,
  output mvn_pkg::norm_res_t     res
);

  localparam int DIV_STEPS = 31;
  localparam int SQRT_STEPS = 16;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SUM, N_SETUP, N_DIV, N_SQRT
  } nstate_t;

  nstate_t                           state_r;
  logic [IN_W-1:0]                   mag_r [3];
  logic [2:0]                        neg_r;
  logic [31:0]                       sq_r [3];
  logic [33:0]                       sum_r;
  logic [33:0]                       rem_r;
  logic [30:0]                       quo_r;
  logic [30:0]                       op_r;
  logic [30:0]                       root_r;
  logic [30:0]                       one_r;
  logic [4:0]                        cnt_r;
  logic [1:0]                        comp_r;
  logic signed [mvn_pkg::NORM_W-1:0] n_r [3];
  logic                              degen_r;
  logic                              done_r;

  logic                              big8;
  logic                              big1;
  logic [34:0]                       shifted;
  logic                              div_ge;
  logic [33:0]                       rem_nxt;
  logic [30:0]                       quo_nxt;
  logic [30:0]                       trial;
  logic                              sqrt_ge;
  logic [30:0]                       op_nxt;
  logic [30:0]                       root_nxt;
  logic [mvn_pkg::NORM_W-1:0]        nmag;
  logic [31:0]                       sq_sel;

  always_comb begin
    big8 = 1'b0;
    big1 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big8 = big8 | ((mag_r[k] >> 24) != '0);
      big1 = big1 | ((mag_r[k] >> 16) != '0);
    end
    sq_sel   = sq_r[comp_r];
    shifted  = {rem_r, (cnt_r == 5'(DIV_STEPS - 1)) ? sq_sel[0] : 1'b0};
    div_ge   = (shifted >= {1'b0, sum_r});
    rem_nxt  = div_ge ? 34'(shifted - {1'b0, sum_r}) : 34'(shifted);
    quo_nxt  = {quo_r[29:0], div_ge};
    trial    = root_r + one_r;
    sqrt_ge  = (op_r >= trial);
    op_nxt   = sqrt_ge ? op_r - trial : op_r;
    root_nxt = sqrt_ge ? (root_r >> 1) + one_r : (root_r >> 1);
    nmag     = mvn_pkg::NORM_W'((root_nxt + 31'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      degen_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            mag_r[0] <= (vec_x < 0) ? IN_W'(-vec_x) : IN_W'(vec_x);
            mag_r[1] <= (vec_y < 0) ? IN_W'(-vec_y) : IN_W'(vec_y);
            mag_r[2] <= (vec_z < 0) ? IN_W'(-vec_z) : IN_W'(vec_z);
            neg_r    <= {vec_z < 0, vec_y < 0, vec_x < 0};
            comp_r   <= '0;
            state_r  <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (big8) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 8;
          end else if (big1) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else begin
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          for (int k = 0; k < 3; k++) sq_r[k] <= mag_r[k][15:0] * mag_r[k][15:0];
          state_r <= N_SUM;
        end
        N_SUM: begin
          sum_r   <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
          state_r <= N_SETUP;
        end
        N_SETUP: begin
          if (sum_r == '0) begin
            for (int k = 0; k < 3; k++) n_r[k] <= '0;
            degen_r <= 1'b1;
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end else begin
            rem_r   <= 34'(sq_sel[31:1]);
            quo_r   <= '0;
            cnt_r   <= 5'(DIV_STEPS - 1);
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == '0) begin
            op_r    <= quo_nxt;
            root_r  <= '0;
            one_r   <= 31'h4000_0000;
            cnt_r   <= 5'(SQRT_STEPS - 1);
            state_r <= N_SQRT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        N_SQRT: begin
          op_r   <= op_nxt;
          root_r <= root_nxt;
          one_r  <= one_r >> 2;
          if (cnt_r == '0) begin
            n_r[comp_r] <= neg_r[comp_r] ? -$signed(nmag) : $signed(nmag);
            if (comp_r == 2'd2) begin
              degen_r <= 1'b0;
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              comp_r  <= comp_r + 1'b1;
              state_r <= N_SETUP;
            end
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign done      = done_r;
  assign res.degen = degen_r;
  assign res.nx    = n_r[0];
  assign res.ny    = n_r[1];
  assign res.nz    = n_r[2];

endmodule

[design/mvn_front.sv]
// ----------------------------------------------------------------------------
// Request front end
// Accepts items, checks their indexes and hands commands to the queue.
// Out-of-range vertex writes are dropped here.
// ----------------------------------------------------------------------------
module mvn_front #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic              in_push,
  input  mvn_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              cmd_full,
  input  logic              init_busy,
  output logic              cmd_push,
  output mvn_pkg::cmd_t     cmd_item
);

  logic a_ok;
  logic b_ok;
  logic c_ok;
  logic bad;
  logic accept;

  always_comb begin
    a_ok = (32'(in_item.vertex_index) < VERTEX_COUNT);
    b_ok = (32'(in_item.corner_b) < VERTEX_COUNT);
    c_ok = (32'(in_item.corner_c) < VERTEX_COUNT);
    unique case (in_item.req_type) inside
      mvn_pkg::REQ_TRI:                      bad = !(a_ok && b_ok && c_ok);
      mvn_pkg::REQ_WRITE, mvn_pkg::REQ_READ: bad = !a_ok;
      default:                               bad = 1'b0;
    endcase
    in_full  = cmd_full || init_busy;
    accept   = in_push && !in_full;
    cmd_push = accept && !((in_item.req_type == mvn_pkg::REQ_WRITE) && bad);
    cmd_item.req   = in_item.req_type;
    cmd_item.bad   = bad;
    cmd_item.idx_a = in_item.vertex_index;
    cmd_item.idx_b = in_item.corner_b;
    cmd_item.idx_c = in_item.corner_c;
    cmd_item.pos_x = in_item.pos_x;
    cmd_item.pos_y = in_item.pos_y;
    cmd_item.pos_z = in_item.pos_z;
  end

endmodule

[design/mvn_back.sv]
// ----------------------------------------------------------------------------
// Command back end
// Sequencer over the position and accumulator memories: vertex writes,
// face normals with accumulation, vertex normal reads and clearing sweeps.
// ----------------------------------------------------------------------------
module mvn_back #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  mvn_pkg::cmd_t      cmd_item,
  output logic               cmd_pop,
  input  logic               out_full,
  output logic               out_push,
  output mvn_pkg::out_item_t out_item,
  output logic               init_busy
);

  localparam int ADDR_W = $clog2(VERTEX_COUNT);
  localparam int CW     = COORD_WIDTH;
  localparam int EW     = CW + 1;
  localparam int PW     = 2 * EW;
  localparam int VW     = PW + 1;
  localparam int ACC_W  = mvn_pkg::ACC_W;
  localparam int NW     = (VW > ACC_W) ? VW : ACC_W;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_RA, S_RB, S_RC, S_RX, S_EDGE, S_MUL, S_CROSS,
    S_VR, S_VRD, S_NSTART, S_NORM, S_ACC_RD, S_ACC_WR, S_EMIT
  } state_t;

  state_t                    state_r;
  mvn_pkg::cmd_t             cur_r;
  logic [ADDR_W-1:0]         clr_cnt_r;
  logic [1:0]                corner_r;
  logic signed [CW-1:0]      pa_r [3];
  logic signed [CW-1:0]      pb_r [3];
  logic signed [CW-1:0]      pc_r [3];
  logic signed [EW-1:0]      e1_r [3];
  logic signed [EW-1:0]      e2_r [3];
  logic signed [PW-1:0]      prod_r [6];
  logic signed [NW-1:0]      v_r [3];
  mvn_pkg::norm_res_t        nres_r;

  logic                      pos_we;
  logic [ADDR_W-1:0]         pos_waddr;
  logic [3*CW-1:0]           pos_wdata;
  logic [ADDR_W-1:0]         pos_raddr;
  logic [3*CW-1:0]           pos_rdata;
  logic                      acc_we;
  logic [ADDR_W-1:0]         acc_waddr;
  logic [3*ACC_W-1:0]        acc_wdata;
  logic [ADDR_W-1:0]         acc_raddr;
  logic [3*ACC_W-1:0]        acc_rdata;

  logic [ADDR_W-1:0]         a_addr;
  logic [ADDR_W-1:0]         b_addr;
  logic [ADDR_W-1:0]         c_addr;
  logic [ADDR_W-1:0]         corner_addr;
  logic signed [31:0]        ext_x;
  logic signed [31:0]        ext_y;
  logic signed [31:0]        ext_z;
  logic signed [CW-1:0]      rd_c [3];
  logic signed [ACC_W-1:0]   acc_c [3];
  logic signed [mvn_pkg::NORM_W-1:0] nv [3];
  logic signed [ACC_W:0]     sum_c [3];
  logic signed [ACC_W-1:0]   sat_c [3];
  logic                      norm_start;
  logic                      norm_done;
  mvn_pkg::norm_res_t        norm_res;

  mvn_ram #(.WIDTH(3 * CW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvn_ram #(.WIDTH(3 * ACC_W), .DEPTH(VERTEX_COUNT)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  mvn_norm #(.IN_W(NW)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec_x (v_r[0]),
    .vec_y (v_r[1]),
    .vec_z (v_r[2]),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_comb begin
    a_addr = ADDR_W'(cur_r.idx_a);
    b_addr = ADDR_W'(cur_r.idx_b);
    c_addr = ADDR_W'(cur_r.idx_c);
    case (corner_r)
      2'd0:    corner_addr = a_addr;
      2'd1:    corner_addr = b_addr;
      default: corner_addr = c_addr;
    endcase

    cmd_pop = (state_r == S_IDLE) && !cmd_empty;

    ext_x     = 32'(cmd_item.pos_x);
    ext_y     = 32'(cmd_item.pos_y);
    ext_z     = 32'(cmd_item.pos_z);
    pos_we    = cmd_pop && (cmd_item.req == mvn_pkg::REQ_WRITE);
    pos_waddr = ADDR_W'(cmd_item.idx_a);
    pos_wdata = {ext_x[CW-1:0], ext_y[CW-1:0], ext_z[CW-1:0]};

    case (state_r)
      S_RB:    pos_raddr = b_addr;
      S_RC:    pos_raddr = c_addr;
      default: pos_raddr = a_addr;
    endcase
    acc_raddr = (state_r == S_ACC_RD) ? corner_addr : a_addr;

    rd_c[0]  = pos_rdata[3*CW-1:2*CW];
    rd_c[1]  = pos_rdata[2*CW-1:CW];
    rd_c[2]  = pos_rdata[CW-1:0];
    acc_c[0] = acc_rdata[3*ACC_W-1:2*ACC_W];
    acc_c[1] = acc_rdata[2*ACC_W-1:ACC_W];
    acc_c[2] = acc_rdata[ACC_W-1:0];
    nv[0]    = nres_r.nx;
    nv[1]    = nres_r.ny;
    nv[2]    = nres_r.nz;
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = (ACC_W + 1)'(acc_c[k]) + (ACC_W + 1)'(nv[k]);
      if (sum_c[k] > mvn_pkg::ACC_MAX) begin
        sat_c[k] = ACC_W'(mvn_pkg::ACC_MAX);
      end else if (sum_c[k] < mvn_pkg::ACC_MIN) begin
        sat_c[k] = ACC_W'(mvn_pkg::ACC_MIN);
      end else begin
        sat_c[k] = ACC_W'(sum_c[k]);
      end
    end

    if (state_r == S_INIT || state_r == S_CLR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt_r;
      acc_wdata = '0;
    end else begin
      acc_we    = (state_r == S_ACC_WR);
      acc_waddr = corner_addr;
      acc_wdata = {sat_c[0], sat_c[1], sat_c[2]};
    end

    norm_start = (state_r == S_NSTART);
    init_busy  = (state_r == S_INIT);
    out_push   = (state_r == S_EMIT) && !out_full;

    out_item.result_kind = (cur_r.req == mvn_pkg::REQ_READ) ?
                           mvn_pkg::KIND_VERTEX : mvn_pkg::KIND_FACE;
    out_item.normal_x    = cur_r.bad ? '0 : nres_r.nx;
    out_item.normal_y    = cur_r.bad ? '0 : nres_r.ny;
    out_item.normal_z    = cur_r.bad ? '0 : nres_r.nz;
    out_item.item_index  = cur_r.idx_a;
    if (cur_r.bad) begin
      out_item.status = mvn_pkg::ST_RANGE;
    end else if (nres_r.degen) begin
      out_item.status = mvn_pkg::ST_DEGEN;
    end else begin
      out_item.status = mvn_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      clr_cnt_r <= '0;
      corner_r  <= '0;
    end else begin
      unique case (state_r) inside
        S_INIT, S_CLR: begin
          if (clr_cnt_r == ADDR_W'(VERTEX_COUNT - 1)) begin
            clr_cnt_r <= '0;
            state_r   <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cur_r <= cmd_item;
            unique case (cmd_item.req)
              mvn_pkg::REQ_CLEAR: state_r <= S_CLR;
              mvn_pkg::REQ_TRI:   state_r <= cmd_item.bad ? S_EMIT : S_RA;
              mvn_pkg::REQ_READ:  state_r <= cmd_item.bad ? S_EMIT : S_VR;
              default:            state_r <= S_IDLE;
            endcase
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          pa_r    <= rd_c;
          state_r <= S_RC;
        end
        S_RC: begin
          pb_r    <= rd_c;
          state_r <= S_RX;
        end
        S_RX: begin
          pc_r    <= rd_c;
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            e1_r[k] <= EW'(pb_r[k]) - EW'(pa_r[k]);
            e2_r[k] <= EW'(pc_r[k]) - EW'(pa_r[k]);
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r[0] <= e1_r[1] * e2_r[2];
          prod_r[1] <= e1_r[2] * e2_r[1];
          prod_r[2] <= e1_r[2] * e2_r[0];
          prod_r[3] <= e1_r[0] * e2_r[2];
          prod_r[4] <= e1_r[0] * e2_r[1];
          prod_r[5] <= e1_r[1] * e2_r[0];
          state_r   <= S_CROSS;
        end
        S_CROSS: begin
          for (int k = 0; k < 3; k++) begin
            v_r[k] <= NW'(VW'(prod_r[2*k]) - VW'(prod_r[2*k+1]));
          end
          state_r <= S_NSTART;
        end
        S_VR: state_r <= S_VRD;
        S_VRD: begin
          for (int k = 0; k < 3; k++) v_r[k] <= NW'(acc_c[k]);
          state_r <= S_NSTART;
        end
        S_NSTART: state_r <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            nres_r <= norm_res;
            if ((cur_r.req == mvn_pkg::REQ_TRI) && !norm_res.degen) begin
              corner_r <= '0;
              state_r  <= S_ACC_RD;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          if (corner_r == 2'd2) begin
            state_r <= S_EMIT;
          end else begin
            corner_r <= corner_r + 1'b1;
            state_r  <= S_ACC_RD;
          end
        end
        S_EMIT: begin
          if (!out_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/mesh_vertex_normal_engine.sv]
// ----------------------------------------------------------------------------
// Mesh vertex normal engine
// Vertex position table with per-vertex normal accumulators. Triangle items
// return a Q1.14 face normal and add it to their corners; read items return
// the normalized accumulated normal of one vertex.
//
// Usage:
//   Items enter through a queue port (in_push, in_full) and results leave
//   through a queue port (out_empty, out_pop). Write and clear items give
//   no result; triangle and read items give one result each, in order.
//   How long a triangle or a read holds the back end depends on the
//   prescale shifts of the normalizer, which runs its bit-serial divider
//   and square root on each component in turn. A zero-length vector ends
//   right after the sum of squares. Up to two items queue ahead of the
//   back end and two results behind it, so a stalled receiver holds the
//   back end only once the result queue is full. After reset the
//   accumulator memory is swept to zero, during which in_full stays
//   high. Position entries hold nothing defined until written.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  mvn_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output mvn_pkg::out_item_t out_item
);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  logic               cmd_push;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               init_busy;
  mvn_pkg::cmd_t      cmd_in;
  mvn_pkg::cmd_t      cmd_out;
  logic               res_push;
  logic               res_full;
  mvn_pkg::out_item_t res_item;

  mvn_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_full  (cmd_full),
    .init_busy (init_busy),
    .cmd_push  (cmd_push),
    .cmd_item  (cmd_in)
  );

  mvn_fifo #(.WIDTH($bits(mvn_pkg::cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mvn_back #(.VERTEX_COUNT(VERTEX_COUNT), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_item  (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_item),
    .init_busy (init_busy)
  );

  mvn_fifo #(.WIDTH($bits(mvn_pkg::out_item_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

[sim/mesh_vertex_normal_engine_tb.sv]
// ----------------------------------------------------------------------------
// Mesh vertex normal engine testbench
// Drives write, triangle, read and clear items through the input queue port
// with random gaps and receiver stalls, predicts every face and vertex normal
// in a local copy of the position table and accumulators, and compares each
// popped result field by field.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine_tb;

  localparam int NVERT = 1024;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    mvn_pkg::in_item_t item;
    bit                drain;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  mvn_pkg::in_item_t  in_item = '0;
  logic               in_full;
  logic               out_empty;
  logic               out_pop = 1'b0;
  mvn_pkg::out_item_t out_item;

  pending_t           pending_items[$];
  mvn_pkg::out_item_t normals_due[$];

  int pos_x[NVERT], pos_y[NVERT], pos_z[NVERT];
  int sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
  bit gen_written[NVERT];
  int gen_list[$];

  int     mismatches = 0;
  int     unexpected = 0;
  longint cycles = 0;
  bit     tx_took = 0;
  int     tx_gap = 0, tx_cnt = 0, drain_cnt = 0;
  int     rx_wait = 0, rx_cnt = 0, rx_hold = 0;
  bit     rx_held_once = 0;

  mesh_vertex_normal_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic mvn_pkg::norm_res_t unit_vec(longint vx, longint vy, longint vz);
    longint             vv[3];
    longint unsigned    m[3];
    longint unsigned    big, sq, lim, t;
    int unsigned        lo, hi, mid;
    int                 s;
    int                 n[3];
    mvn_pkg::norm_res_t r;
    vv[0] = vx; vv[1] = vy; vv[2] = vz;
    for (int i = 0; i < 3; i++) m[i] = vv[i] < 0 ? -vv[i] : vv[i];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    s = 0;
    while ((big >> s) >= 65536) s++;
    for (int i = 0; i < 3; i++) m[i] = m[i] >> s;
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = '0;
    if (sq == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      lo = 0;
      hi = 16384;
      lim = (m[i] * m[i]) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = 2 * longint'(mid) - 1;
        if (t * t * sq <= lim) lo = mid;
        else hi = mid - 1;
      end
      n[i] = vv[i] < 0 ? -int'(lo) : int'(lo);
    end
    r.nx = 16'(n[0]);
    r.ny = 16'(n[1]);
    r.nz = 16'(n[2]);
    return r;
  endfunction

  function automatic int acc_add(int a, int b);
    longint r;
    r = longint'(a) + longint'(b);
    if (r > 33554431) r = 33554431;
    if (r < -33554432) r = -33554432;
    return int'(r);
  endfunction

  task automatic predict_normal(mvn_pkg::in_item_t it);
    mvn_pkg::out_item_t e;
    mvn_pkg::norm_res_t r;
    int                 a, b, c;
    longint             e1x, e1y, e1z, e2x, e2y, e2z;
    a = it.vertex_index;
    b = it.corner_b;
    c = it.corner_c;
    e = '0;
    e.item_index = it.vertex_index;
    case (it.req_type)
      mvn_pkg::REQ_WRITE: begin
        pos_x[a] = it.pos_x;
        pos_y[a] = it.pos_y;
        pos_z[a] = it.pos_z;
      end
      mvn_pkg::REQ_CLEAR: begin
        for (int i = 0; i < NVERT; i++) begin
          sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
        end
      end
      mvn_pkg::REQ_READ: begin
        r = unit_vec(sum_x[a], sum_y[a], sum_z[a]);
        e.result_kind = mvn_pkg::KIND_VERTEX;
        e.normal_x = r.nx; e.normal_y = r.ny; e.normal_z = r.nz;
        e.status = r.degen ? mvn_pkg::ST_DEGEN : mvn_pkg::ST_OK;
        normals_due = {normals_due, e};
      end
      default: begin
        e1x = pos_x[b] - pos_x[a]; e1y = pos_y[b] - pos_y[a]; e1z = pos_z[b] - pos_z[a];
        e2x = pos_x[c] - pos_x[a]; e2y = pos_y[c] - pos_y[a]; e2z = pos_z[c] - pos_z[a];
        r = unit_vec(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z, e1x * e2y - e1y * e2x);
        if (!r.degen) begin
          sum_x[a] = acc_add(sum_x[a], r.nx); sum_y[a] = acc_add(sum_y[a], r.ny);
          sum_z[a] = acc_add(sum_z[a], r.nz);
          sum_x[b] = acc_add(sum_x[b], r.nx); sum_y[b] = acc_add(sum_y[b], r.ny);
          sum_z[b] = acc_add(sum_z[b], r.nz);
          sum_x[c] = acc_add(sum_x[c], r.nx); sum_y[c] = acc_add(sum_y[c], r.ny);
          sum_z[c] = acc_add(sum_z[c], r.nz);
        end
        e.result_kind = mvn_pkg::KIND_FACE;
        e.normal_x = r.nx; e.normal_y = r.ny; e.normal_z = r.nz;
        e.status = r.degen ? mvn_pkg::ST_DEGEN : mvn_pkg::ST_OK;
        normals_due = {normals_due, e};
      end
    endcase
  endtask

  task automatic add_item(logic [1:0] req, int a, int b, int c,
                          int x, int y, int z, bit drain = 0);
    pending_t p;
    p.item.req_type = req;
    p.item.vertex_index = 10'(a);
    p.item.corner_b = 10'(b);
    p.item.corner_c = 10'(c);
    p.item.pos_x = 16'(x);
    p.item.pos_y = 16'(y);
    p.item.pos_z = 16'(z);
    p.drain = drain;
    if (req == mvn_pkg::REQ_WRITE && !gen_written[a]) begin
      gen_written[a] = 1;
      gen_list = {gen_list, a};
    end
    pending_items = {pending_items, p};
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2) == 0 ? -32768 : ($urandom_range(0, 1) ? 32767 : 0);
      1: return int'($urandom_range(0, 2048)) - 1024;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic add_write(int a);
    add_item(mvn_pkg::REQ_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
             rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    int sel, a;
    add_item(mvn_pkg::REQ_WRITE, 0, 0, 0, -32768, -32768, -32768);
    add_item(mvn_pkg::REQ_WRITE, 1, 0, 0, 32767, -32768, -32768);
    add_item(mvn_pkg::REQ_WRITE, 2, 0, 0, -32768, 32767, -32768);
    add_item(mvn_pkg::REQ_WRITE, 3, 1023, 1023, 32767, 32767, 32767);
    add_item(mvn_pkg::REQ_TRI, 0, 1, 2, 0, 0, 0);
    add_item(mvn_pkg::REQ_TRI, 0, 1, 3, 0, 0, 0);
    add_item(mvn_pkg::REQ_TRI, 0, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_WRITE, 4, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_WRITE, 5, 0, 0, 256, 256, 256);
    add_item(mvn_pkg::REQ_WRITE, 6, 0, 0, 512, 512, 512);
    add_item(mvn_pkg::REQ_TRI, 4, 5, 6, 0, 0, 0);
    add_item(mvn_pkg::REQ_WRITE, 1023, 0, 0, 1, -1, 256);
    add_item(mvn_pkg::REQ_TRI, 1023, 0, 2, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 1023, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 512, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 3, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    add_item(mvn_pkg::REQ_TRI, 3, 2, 1, 0, 0, 0);
    add_item(mvn_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 1);

    for (int i = 0; i < 430; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30 || gen_list.size() < 3) add_write($urandom_range(0, 1023));
      else if (sel < 72) begin
        a = gen_list[$urandom_range(0, gen_list.size() - 1)];
        add_item(mvn_pkg::REQ_TRI, a, gen_list[$urandom_range(0, gen_list.size() - 1)],
                 gen_list[$urandom_range(0, gen_list.size() - 1)],
                 rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 96) begin
        a = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                      : gen_list[$urandom_range(0, gen_list.size() - 1)];
        add_item(mvn_pkg::REQ_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 rand_coord(), rand_coord(), rand_coord(), i % 150 == 149);
      end else
        add_item(mvn_pkg::REQ_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_push && normals_due.size() == 0);
    repeat (1500) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && normals_due.size() == 0) begin
      $display("mesh_vertex_normal_engine_tb OK");
    end else begin
      $display("mesh_vertex_normal_engine_tb NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    mvn_pkg::out_item_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mesh_vertex_normal_engine_tb NOT OK");
      $finish;
    end
    if (rst_n && out_pop && !out_empty) begin
      rx_cnt++;
      rx_wait = ((rx_cnt / 80) % 3 == 0) ? 0 : $urandom_range(0, 7);
      if (normals_due.size() == 0) begin
        unexpected++;
        if (unexpected + mismatches <= 10)
          $display("unexpected result %p", out_item);
      end else begin
        e = normals_due.pop_front();
        if (out_item.result_kind !== e.result_kind || out_item.normal_x !== e.normal_x ||
            out_item.normal_y !== e.normal_y || out_item.normal_z !== e.normal_z ||
            out_item.item_index !== e.item_index || out_item.status !== e.status) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected %p got %p", e, out_item);
        end
      end
    end
    if (rst_n && in_push && !in_full) begin
      tx_took = 1;
      predict_normal(in_item);
    end
  end

  always @(negedge clk) begin
    logic              nxt_push;
    mvn_pkg::in_item_t nxt;
    pending_t          p;
    nxt_push = in_push;
    nxt = in_item;
    if (tx_took) begin
      nxt_push = 1'b0;
      tx_took = 0;
    end
    if (rst_n && !nxt_push) begin
      if (tx_gap > 0) tx_gap--;
      else if (pending_items.size() > 0) begin
        if (pending_items[0].drain && (normals_due.size() != 0 || drain_cnt < 1200)) begin
          drain_cnt = normals_due.size() != 0 ? 0 : drain_cnt + 1;
        end else begin
          p = pending_items.pop_front();
          nxt = p.item;
          nxt_push = 1'b1;
          drain_cnt = 0;
          tx_cnt++;
          tx_gap = ((tx_cnt / 64) % 3 == 1) ? 0 : $urandom_range(0, 7);
        end
      end
    end
    in_push <= nxt_push;
    in_item <= nxt;
  end

  always @(negedge clk) begin
    if (rx_cnt == 30 && !rx_held_once) begin
      rx_held_once = 1;
      rx_hold = 3000;
    end
    if (!rst_n) out_pop <= 1'b0;
    else if (rx_hold > 0) begin
      rx_hold--;
      out_pop <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_pop <= 1'b0;
    end else out_pop <= 1'b1;
  end

endmodule
